// ===== sv/fht_pkg.sv =====
// Shared types and constants for the fault history table.
`default_nettype none

package fht_pkg;

  // Saturation limit of the per-entry fail counter.
  localparam logic [7:0] CNT_SAT_MAX = 8'd255;

  // A report never emits more than this many ring words.
  localparam int REPORT_CAP = 4;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 4;

  // Input tdata field positions.
  localparam int IN_ID_LSB   = 0;
  localparam int IN_IND_BIT  = 8;
  localparam int IN_DATA_LSB = 9;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_BAD_ID     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERRUN_ID = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOG     = 2'd0,
    ACT_REPORT  = 2'd1,
    ACT_SERVICE = 2'd2,
    ACT_CLEAR   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_LOG_ACK   = 2'd0,
    KIND_REPORT    = 2'd1,
    KIND_SERVICE   = 2'd2,
    KIND_CLEAR_ACK = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOG_RD,
    S_LOG_WR,
    S_FILL,
    S_LOG_ACK,
    S_REP_RD,
    S_REP_EMIT,
    S_SVC,
    S_CLR
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic  load;      // latch the input word
    logic  log_rd;    // read entry of the logged row
    logic  log_wr;    // apply the log update
    logic  fill_wr;   // write one slot of a fresh row
    logic  rep_rd;    // read entry and ring word for a report
    logic  slot_clr;
    logic  slot_inc;
    logic  out_load;  // load the output register
    kind_t out_kind;
    logic  pend_clr;
    logic  clr_all;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    act_t in_act;     // action on the input port
    logic in_id_ok;   // input fault ID in range
    act_t act;        // latched action
    logic eff_ok;     // logged row exists
    logic need_fill;  // fail log into an empty row
    logic fill_last;
    logic rep_last;
    logic out_free;   // output register can take a word
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/fht_ctrl.sv =====
// Controller state machine for the fault history table.
`default_nettype none

module fht_ctrl import fht_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  state_t after_log;

  // where to go once the log part of an item is done
  assign after_log = (sts.act == ACT_LOG) ? S_LOG_ACK : S_REP_RD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (sts.in_act)
            ACT_LOG:     state_nxt = S_LOG_RD;
            ACT_REPORT:  state_nxt = sts.in_id_ok ? S_REP_RD : S_LOG_RD;
            ACT_SERVICE: state_nxt = S_SVC;
            ACT_CLEAR:   state_nxt = S_CLR;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOG_RD:   state_nxt = sts.eff_ok ? S_LOG_WR : after_log;
      S_LOG_WR:   state_nxt = sts.need_fill ? S_FILL : after_log;
      S_FILL:     state_nxt = sts.fill_last ? after_log : S_FILL;
      S_LOG_ACK:  state_nxt = sts.out_free ? S_IDLE : S_LOG_ACK;
      S_REP_RD:   state_nxt = S_REP_EMIT;
      S_REP_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.rep_last ? S_IDLE : S_REP_RD;
        end
      end
      S_SVC:      state_nxt = sts.out_free ? S_IDLE : S_SVC;
      S_CLR:      state_nxt = sts.out_free ? S_IDLE : S_CLR;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_LOG_RD: cmd.log_rd = sts.eff_ok;
      S_LOG_WR: cmd.log_wr = 1'b1;
      S_FILL: begin
        cmd.fill_wr  = 1'b1;
        cmd.slot_inc = !sts.fill_last;
        cmd.slot_clr = sts.fill_last;
      end
      S_LOG_ACK: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_LOG_ACK;
      end
      S_REP_RD: cmd.rep_rd = 1'b1;
      S_REP_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_REPORT;
        cmd.slot_inc = sts.out_free && !sts.rep_last;
      end
      S_SVC: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_SERVICE;
        cmd.pend_clr = sts.out_free;
      end
      S_CLR: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = KIND_CLEAR_ACK;
        cmd.clr_all  = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/fht_dp.sv =====
// Datapath of the fault history table: entry memories, config and output register.
`default_nettype none

module fht_dp import fht_pkg::*; #(
  parameter int NUM_FAULTS    = 16,
  parameter int HISTORY_DEPTH = 4
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  input  wire [1:0]              in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  wire                    cfg_we,
  input  wire [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int IDW  = $clog2(NUM_FAULTS);
  localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int NENT = NUM_FAULTS * HISTORY_DEPTH;
  localparam int HAW  = $clog2(NENT);
  localparam int NREP = (HISTORY_DEPTH < REPORT_CAP) ? HISTORY_DEPTH : REPORT_CAP;
  localparam logic [8:0]     NF_LIM   = 9'(NUM_FAULTS);
  localparam logic [HW-1:0]  HEAD_MAX = HW'(HISTORY_DEPTH - 1);
  localparam logic [HW-1:0]  REP_END  = HW'(NREP - 1);
  localparam logic [HAW-1:0] HD_A     = HAW'(HISTORY_DEPTH);

  // latched item and config
  act_t         act_r;
  logic [7:0]   id_r;
  logic         ind_r;
  logic [31:0]  data_r;
  logic [3:0]   bad_r;
  logic [3:0]   ovr_r;
  logic         pend_r;
  logic [HW-1:0] slot_r;

  // entry store; a row whose valid bit is low reads as all zero
  logic [NUM_FAULTS-1:0] rvld_r;
  logic [7:0]    cnt_mem  [NUM_FAULTS];
  logic [HW-1:0] head_mem [NUM_FAULTS];
  logic [31:0]   hist_mem [NENT];
  logic          rowv_r;
  logic [7:0]    cnt_rd_r;
  logic [HW-1:0] head_rd_r;
  logic [31:0]   hist_rd_r;

  // output register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_cnt_r,  out_cnt_nxt;
  logic [1:0]  out_head_r, out_head_nxt;
  logic [1:0]  out_idx_r,  out_idx_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_ok_r,   out_ok_nxt;
  logic        out_wr_r,   out_wr_nxt;
  logic        out_pend_r, out_pend_nxt;

  logic          id_ok, in_ok, eff_ok, eff_fail;
  logic [7:0]    eff_id8;
  logic [31:0]   eff_data;
  logic [IDW-1:0] row;
  logic [7:0]    cnt_cur, cnt_inc;
  logic [HW-1:0] head_cur, head_inc, wslot;
  logic [HAW-1:0] row_base, haddr_w, haddr_r;
  logic [31:0]   wdata;
  logic          hist_we, meta_we, pend_set;
  logic [3:0]    head4, slot4;
  logic          is_rep, show;

  // out-of-range IDs are redirected as a fail on the bad-fault row
  assign id_ok    = {1'b0, id_r} < NF_LIM;
  assign in_ok    = {1'b0, in_tdata[IN_ID_LSB +: 8]} < NF_LIM;
  assign eff_id8  = id_ok ? id_r : {4'b0, bad_r};
  assign eff_ok   = id_ok || ({5'b0, bad_r} < NF_LIM);
  assign eff_fail = id_ok ? ind_r : 1'b1;
  assign eff_data = id_ok ? data_r : {24'b0, id_r};
  assign row      = eff_id8[IDW-1:0];

  assign cnt_cur  = rowv_r ? cnt_rd_r : 8'd0;
  assign head_cur = rowv_r ? head_rd_r : '0;
  assign cnt_inc  = (cnt_cur == CNT_SAT_MAX) ? cnt_cur : cnt_cur + 8'd1;
  assign head_inc = (head_cur == HEAD_MAX) ? '0 : head_cur + HW'(1);

  assign row_base = HAW'(row) * HD_A;
  assign wslot    = cmd.fill_wr ? slot_r : head_cur;
  assign haddr_w  = row_base + HAW'(wslot);
  assign haddr_r  = row_base + HAW'(slot_r);
  assign wdata    = (cmd.fill_wr && (slot_r != '0)) ? 32'd0 : eff_data;
  assign hist_we  = (cmd.log_wr && eff_fail && rowv_r) || cmd.fill_wr;
  assign meta_we  = cmd.log_wr && eff_fail;
  assign pend_set = cmd.log_wr && (eff_id8 != {4'b0, ovr_r});

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[haddr_w] <= wdata;
    end
    if (cmd.rep_rd) begin
      hist_rd_r <= hist_mem[haddr_r];
    end
    if (meta_we) begin
      cnt_mem[row]  <= cnt_inc;
      head_mem[row] <= head_inc;
    end
    if (cmd.log_rd || cmd.rep_rd) begin
      cnt_rd_r  <= cnt_mem[row];
      head_rd_r <= head_mem[row];
      rowv_r    <= rvld_r[row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= '0;
    end else if (cmd.clr_all) begin
      rvld_r <= '0;
    end else if (cmd.log_wr) begin
      if (!eff_fail) begin
        rvld_r[row] <= 1'b0;
      end else if (!rowv_r) begin
        rvld_r[row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r   <= in_tdata[IN_ID_LSB +: 8];
      ind_r  <= in_tdata[IN_IND_BIT];
      data_r <= in_tdata[IN_DATA_LSB +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= ACT_LOG;
      bad_r  <= 4'd0;
      ovr_r  <= 4'd1;
      pend_r <= 1'b0;
      slot_r <= '0;
    end else begin
      if (cmd.load) begin
        act_r <= act_t'(in_tuser);
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BAD_ID:     bad_r <= cfg_wdata;
          CFG_OVERRUN_ID: ovr_r <= cfg_wdata;
          default:        ;
        endcase
      end
      if (cmd.clr_all || cmd.pend_clr) begin
        pend_r <= 1'b0;
      end else if (pend_set) begin
        pend_r <= 1'b1;
      end
      if (cmd.load || cmd.slot_clr) begin
        slot_r <= '0;
      end else if (cmd.slot_inc) begin
        slot_r <= slot_r + HW'(1);
      end
    end
  end

  assign head4  = 4'(head_rd_r);
  assign slot4  = 4'(slot_r);
  assign is_rep = (cmd.out_kind == KIND_REPORT);
  assign show   = is_rep && id_ok && rowv_r;

  always_comb begin
    out_cnt_nxt  = show ? cnt_rd_r : 8'd0;
    out_head_nxt = show ? head4[1:0] : 2'd0;
    out_idx_nxt  = is_rep ? slot4[1:0] : 2'd0;
    out_word_nxt = show ? hist_rd_r : 32'd0;
    out_last_nxt = !is_rep || (slot_r == REP_END);
    out_ok_nxt   = ((cmd.out_kind == KIND_LOG_ACK) || is_rep) && id_ok;
    out_wr_nxt   = (cmd.out_kind == KIND_SERVICE) && pend_r;
    out_pend_nxt = ((cmd.out_kind == KIND_LOG_ACK) || is_rep) && pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_cnt_r  <= out_cnt_nxt;
      out_head_r <= out_head_nxt;
      out_idx_r  <= out_idx_nxt;
      out_word_r <= out_word_nxt;
      out_last_r <= out_last_nxt;
      out_ok_r   <= out_ok_nxt;
      out_wr_r   <= out_wr_nxt;
      out_pend_r <= out_pend_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_pend_r, out_wr_r, out_ok_r, out_word_r,
                       out_idx_r, out_head_r, out_cnt_r};

  always_comb begin
    sts           = '0;
    sts.in_act    = act_t'(in_tuser);
    sts.in_id_ok  = in_ok;
    sts.act       = act_r;
    sts.eff_ok    = eff_ok;
    sts.need_fill = eff_fail && !rowv_r;
    sts.fill_last = (slot_r == HEAD_MAX);
    sts.rep_last  = (slot_r == REP_END);
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

`default_nettype wire

// ===== sv/fault_history_table.sv =====
// Top level of the fault history table: controller, datapath and checks.
`default_nettype none

// Fault history table. One entry per fault ID holds a saturating 8-bit fail
// count, a ring head and a ring of HISTORY_DEPTH 32-bit troubleshooting
// words. Input words select an action on in_tuser (log, report, service,
// clear). A log with pass clears the entry; a log with fail stores ts_data
// at the head, counts up to 255 and advances the head. Out-of-range IDs are
// logged as a fail on the bad-fault entry with the ID as the word. Every log
// sets the pending flag unless it hits the overrun ID. A report returns
// min(HISTORY_DEPTH, 4) words, the last with out_tlast; a bad ID reports
// zeros after being logged. Service returns the pending flag as a write
// request and clears it; clear empties the whole table at once.
// Flow: one item is in flight at a time, the ring memory has one port with
// a registered read. Service and clear emit one word; a log reads the entry,
// writes it, zero-fills the ring row on the first fail into an empty entry
// and emits an acknowledge; a report reads and emits each word in turn, and
// for a bad ID first runs the log steps. Output stalls hold the emitting
// step. Each row carries a valid bit cleared at reset, so no clearing pass
// is needed after reset.
// Config writes (cfg_addr 0 bad-fault ID, 1 overrun ID) take effect at once
// and are meant for an idle block.

module fault_history_table import fht_pkg::*; #(
  parameter int NUM_FAULTS    = 16,
  parameter int HISTORY_DEPTH = 4
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input words
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // flt_id[7:0] indicator[8] ts_data[40:9]
  input  wire [1:0]              in_tuser,   // action[1:0]
  // result words
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // count[7:0] head[9:8] word_index[11:10]
                                             // word[43:12] id_ok[44] write_request[45]
                                             // pending[46]
  output logic [1:0]             out_tuser,  // kind[1:0]
  output logic                   out_tlast,
  // configuration
  input  wire                    cfg_we,
  input  wire [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  fht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fht_dp #(
    .NUM_FAULTS    (NUM_FAULTS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register loaded while holding an untaken word");

  // one item at a time: an accepted word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // only report words can be non-final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_REPORT)) |-> out_tlast)
    else $error("single-word result without tlast");

  // the ring memory and row valid bits see one update source per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.log_wr, cmd.fill_wr, cmd.clr_all}))
    else $error("conflicting table updates");

endmodule

`default_nettype wire
